### hw/rtl/w36bs_pkg.sv
// Package: shared types, codes and constants of the 36-bit word to byte stream encoder.
`timescale 1ns / 1ps

package w36bs_pkg;

  // Widths of the fields carried on the channels.
  localparam int WORD_W  = 36;
  localparam int BYTE_W  = 8;
  localparam int FMT_W   = 3;
  localparam int MAX_BYTES = 6;
  localparam int CNT_W   = 3;

  // Output format selected by the configuration register.
  typedef enum logic [FMT_W-1:0] {
    FMT_UNIX   = 3'd0,
    FMT_HDENS  = 3'd1,
    FMT_CORE   = 3'd2,
    FMT_ANSI   = 3'd3,
    FMT_TEXT   = 3'd4,
    FMT_SIXBIT = 3'd5
  } fmt_t;

  // Operation carried with each input word.
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Text characters handled by the newline-text format.
  localparam logic [6:0] CH_CR = 7'o15;
  localparam logic [6:0] CH_LF = 7'o12;
  localparam logic [6:0] CH_NL = 7'o12;

  // Marker nibble in the upper half of the first byte of a unixified word.
  localparam logic [3:0] UNIX_MARK = 4'hF;

  // Bytes produced by one input word, first byte in entry zero.
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]                 cnt;
  } job_t;

endpackage

### hw/rtl/w36bs_if.sv
// Interfaces: the input word channel and the output byte channel.
`timescale 1ns / 1ps

interface w36bs_in_if import w36bs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [WORD_W-1:0] word;

  modport source (output valid, output op, output word, input ready);
  modport sink   (input valid, input op, input word, output ready);
endinterface

interface w36bs_out_if import w36bs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_out;
  logic              last;

  modport source (output valid, output byte_out, output last, input ready);
  modport sink   (input valid, input byte_out, input last, output ready);
endinterface

### hw/rtl/w36bs_front.sv
// Front end: accepts words, holds the format register and carry state, builds byte lists.
`timescale 1ns / 1ps

module w36bs_front import w36bs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  w36bs_in_if.sink         in_ch,
  input  logic             cfg_we,
  input  logic [FMT_W-1:0] cfg_wdata,
  input  logic             q_full,
  output logic             push_valid,
  output job_t             push_job
);

  fmt_t       format_r;
  logic       nibble_held_r, nibble_held_nxt;
  logic [3:0] held_bits_r, held_bits_nxt;
  logic       cr_held_r, cr_held_nxt;
  logic       accept;

  // Newline-text scan results.
  logic [MAX_BYTES-1:0][BYTE_W-1:0] tbytes;
  logic [CNT_W-1:0]                 tcnt;
  logic                             tcr;

  job_t       job;
  logic [WORD_W-1:0] w;

  assign w           = in_ch.word;
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = accept && (job.cnt != '0);
  assign push_job    = job;

  // Newline text: scan the characters, folding CR-LF into NL and holding a trailing CR.
  always_comb begin
    logic [MAX_BYTES:0][6:0] ch;
    logic [CNT_W-1:0]        n;
    logic [CNT_W-1:0]        k;
    logic                    skip;
    ch     = '0;
    tbytes = '0;
    k      = '0;
    skip   = 1'b0;
    tcr    = 1'b0;
    if (cr_held_r) begin
      ch[0] = CH_CR;
      ch[1] = w[35:29];
      ch[2] = w[28:22];
      ch[3] = w[21:15];
      ch[4] = w[14:8];
      ch[5] = w[7:1];
      n     = 3'd6;
    end else begin
      ch[0] = w[35:29];
      ch[1] = w[28:22];
      ch[2] = w[21:15];
      ch[3] = w[14:8];
      ch[4] = w[7:1];
      n     = 3'd5;
    end
    for (int i = 0; i < MAX_BYTES; i++) begin
      if (CNT_W'(i) < n) begin
        if (skip) begin
          skip = 1'b0;
        end else if (ch[i] == CH_CR) begin
          if (CNT_W'(i) == n - 3'd1) begin
            tcr = 1'b1;
          end else if (ch[i+1] == CH_LF) begin
            tbytes[k] = {1'b0, CH_NL};
            k         = k + 3'd1;
            skip      = 1'b1;
          end else begin
            tbytes[k]        = {1'b0, ch[i]};
            tbytes[k + 3'd1] = {1'b0, ch[i+1]};
            k                = k + 3'd2;
            skip             = 1'b1;
          end
        end else begin
          tbytes[k] = {1'b0, ch[i]};
          k         = k + 3'd1;
        end
      end
    end
    tcnt = k;
  end

  // Classify the word by operation and format, and work out the next carry state.
  always_comb begin
    job             = '0;
    nibble_held_nxt = nibble_held_r;
    held_bits_nxt   = held_bits_r;
    cr_held_nxt     = cr_held_r;
    if (in_ch.op == OP_FLUSH) begin
      if (format_r == FMT_HDENS && nibble_held_r) begin
        job.bytes[0]    = {held_bits_r, 4'h0};
        job.cnt         = 3'd1;
        nibble_held_nxt = 1'b0;
        held_bits_nxt   = 4'h0;
      end else if (format_r == FMT_TEXT && cr_held_r) begin
        job.bytes[0] = {1'b0, CH_CR};
        job.cnt      = 3'd1;
        cr_held_nxt  = 1'b0;
      end
    end else begin
      case (format_r)
        FMT_UNIX: begin
          job.bytes[0] = {UNIX_MARK, w[35:32]};
          job.bytes[1] = w[31:24];
          job.bytes[2] = w[23:16];
          job.bytes[3] = w[15:8];
          job.bytes[4] = w[7:0];
          job.cnt      = 3'd5;
        end
        FMT_HDENS: begin
          if (!nibble_held_r) begin
            job.bytes[0]    = w[35:28];
            job.bytes[1]    = w[27:20];
            job.bytes[2]    = w[19:12];
            job.bytes[3]    = w[11:4];
            job.cnt         = 3'd4;
            held_bits_nxt   = w[3:0];
            nibble_held_nxt = 1'b1;
          end else begin
            job.bytes[0]    = {held_bits_r, w[35:32]};
            job.bytes[1]    = w[31:24];
            job.bytes[2]    = w[23:16];
            job.bytes[3]    = w[15:8];
            job.bytes[4]    = w[7:0];
            job.cnt         = 3'd5;
            held_bits_nxt   = 4'h0;
            nibble_held_nxt = 1'b0;
          end
        end
        FMT_CORE: begin
          job.bytes[0] = w[35:28];
          job.bytes[1] = w[27:20];
          job.bytes[2] = w[19:12];
          job.bytes[3] = w[11:4];
          job.bytes[4] = {4'h0, w[3:0]};
          job.cnt      = 3'd5;
        end
        FMT_ANSI: begin
          job.bytes[0] = {1'b0, w[35:29]};
          job.bytes[1] = {1'b0, w[28:22]};
          job.bytes[2] = {1'b0, w[21:15]};
          job.bytes[3] = {1'b0, w[14:8]};
          job.bytes[4] = {w[0], w[7:1]};
          job.cnt      = 3'd5;
        end
        FMT_TEXT: begin
          job.bytes   = tbytes;
          job.cnt     = tcnt;
          cr_held_nxt = tcr;
        end
        FMT_SIXBIT: begin
          job.bytes[0] = {2'b00, w[35:30]};
          job.bytes[1] = {2'b00, w[29:24]};
          job.bytes[2] = {2'b00, w[23:18]};
          job.bytes[3] = {2'b00, w[17:12]};
          job.bytes[4] = {2'b00, w[11:6]};
          job.bytes[5] = {2'b00, w[5:0]};
          job.cnt      = 3'd6;
        end
        default: begin
          job = '0;
        end
      endcase
    end
  end

  // Format register and carry state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r      <= FMT_UNIX;
      nibble_held_r <= 1'b0;
      held_bits_r   <= 4'h0;
      cr_held_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        format_r <= fmt_t'(cfg_wdata);
      end
      if (accept) begin
        nibble_held_r <= nibble_held_nxt;
        held_bits_r   <= held_bits_nxt;
        cr_held_r     <= cr_held_nxt;
      end
    end
  end

endmodule

### hw/rtl/w36bs_queue.sv
// Two-entry queue of byte lists between the front end and the byte serialiser.
`timescale 1ns / 1ps

module w36bs_queue import w36bs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push_valid ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push_valid} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### hw/rtl/w36bs_back.sv
// Back end: sends the queued bytes one per cycle, while the output channel is ready, through an output register.
`timescale 1ns / 1ps

module w36bs_back import w36bs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic [CNT_W-1:0] idx,
  w36bs_out_if.source out_ch
);

  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              load;
  logic              at_end;

  assign load   = head_valid && (!out_valid_r || out_ch.ready);
  assign at_end = (idx_r == head_job.cnt - 3'd1);
  assign pop    = load && at_end;
  assign idx    = idx_r;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.byte_out = out_byte_r;
  assign out_ch.last     = out_last_r;

  // Byte index within the head list and output register occupancy.
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = at_end ? '0 : idx_r + 3'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= head_job.bytes[idx_r];
      out_last_r <= at_end;
    end
  end

endmodule

### hw/rtl/word36_to_byte_stream_encoder.sv
// Top level: 36-bit word to byte stream encoder.
//
//   Channel  | Direction | Handshake         | Carries
//   ---------+-----------+-------------------+------------------------------
//   in_ch    | in        | valid/ready       | op, word (36 bits)
//   out_ch   | out       | valid/ready       | byte_out (8 bits), last
//   cfg      | in        | cfg_we            | cfg_wdata (format, 3 bits)
//
// A word's bytes leave one per cycle while the output channel is ready, so the output
// channel sets the word rate. A word that yields no byte is taken without entering the
// queue. The first byte of a word is presented after passing through a queue entry and
// the output register. Reset is synchronous and clears the queue, the carry state and
// the format (unixified). Two byte lists queue up between the front end and the
// serialiser, so input stalls only once both entries are full.
`timescale 1ns / 1ps

module word36_to_byte_stream_encoder import w36bs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  w36bs_in_if.sink         in_ch,
  w36bs_out_if.source      out_ch,
  input  logic             cfg_we,
  input  logic [FMT_W-1:0] cfg_wdata
);

  logic             push_valid;
  job_t             push_job;
  logic             q_full;
  logic             pop;
  logic             head_valid;
  job_t             head_job;
  logic [CNT_W-1:0] back_idx;

  // Accept and classify words.
  w36bs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  // Decoupling queue.
  w36bs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Serialise bytes onto the output.
  w36bs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .idx        (back_idx),
    .out_ch     (out_ch)
  );

  // A word is never pushed into a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !q_full)
    else $error("word pushed into a full queue");

  // Every queued list holds between one and six bytes.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (push_job.cnt != 3'd0 && push_job.cnt <= 3'd6))
    else $error("queued byte count out of range");

  // The serialiser index stays inside the head list.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (back_idx < head_job.cnt))
    else $error("byte index beyond head list");

  // A popped list leaves the serialiser at its first byte.
  a_idx_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (back_idx == 3'd0))
    else $error("byte index not rewound after the last byte");

endmodule
